// File: src/rank_bucket_histogram_defines.svh
// rank_bucket_histogram_defines.svh: assertion macros for the histogram block.
// Depends on nothing; taken in by the top level.
`ifndef RANK_BUCKET_HISTOGRAM_DEFINES_SVH
`define RANK_BUCKET_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define RBH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define RBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rbh_pkg.sv
// rbh_pkg: shared constants, types and register codes of the rank histogram.
// No dependencies; used by every module of the block.
package rbh_pkg;

    // Field widths
    localparam int RANK_W  = 21;
    localparam int WIDTH_W = 17;
    localparam int COUNT_W = 21;
    localparam int TOTAL_W = 32;
    localparam int BINNO_W = 6;

    // Default bin count and its upper bound
    localparam int BINS_DEF = 64;

    // Divider: numerator holds item_count + width - 1, quotient clamps at 64
    localparam int NUM_W  = 22;
    localparam int DEN_W  = WIDTH_W;
    localparam int QW     = 7;
    localparam int STEP_W = 3;

    // Register reset values
    localparam logic [WIDTH_W-1:0] BUCKET_WIDTH_RST = 17'd512;
    localparam logic [COUNT_W-1:0] ITEM_COUNT_RST   = 21'd32768;

    // Counter saturation value
    localparam logic [TOTAL_W-1:0] CNT_MAX = '1;

    // Configuration register index (paddr[2])
    localparam logic REG_BUCKET_WIDTH = 1'b0;
    localparam logic REG_ITEM_COUNT   = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_UPD,
        S_DUMP
    } t_state;

endpackage

// File: src/rbh_div.sv
// rbh_div: iterative restoring divider, one quotient bit per cycle, quotient
// clamped at 2**(QW-1). Depends on rbh_pkg.
module rbh_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rbh_pkg::NUM_W-1:0]    i_num,
    input  logic [rbh_pkg::DEN_W-1:0]    i_den,
    output logic                         o_done,
    output logic [rbh_pkg::QW-1:0]       o_quot
);

    localparam int SH_W = rbh_pkg::DEN_W + rbh_pkg::QW - 1;
    localparam logic [rbh_pkg::STEP_W-1:0] STEP_TOP = rbh_pkg::STEP_W'(rbh_pkg::QW - 1);

    logic [rbh_pkg::NUM_W-1:0]  r_rem;
    logic [SH_W-1:0]            r_dsh;
    logic [rbh_pkg::STEP_W-1:0] r_step;
    logic [rbh_pkg::QW-1:0]     r_q;
    logic                       r_busy;
    logic                       r_done;
    logic                       ge;

    // trial subtract of the shifted divisor
    assign ge = (SH_W'(r_rem) >= r_dsh);

    // control: busy and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath: top step flags a quotient at or over the clamp
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {i_den, {(rbh_pkg::QW-1){1'b0}}};
            r_step <= STEP_TOP;
            r_q    <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem       <= r_rem - rbh_pkg::NUM_W'(r_dsh);
                r_q[r_step] <= 1'b1;
            end
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[rbh_pkg::QW-1]
                  ? {1'b1, {(rbh_pkg::QW-1){1'b0}}}
                  : {1'b0, r_q[rbh_pkg::QW-2:0]};

endmodule

// File: src/rbh_ram.sv
// rbh_ram: bin counter memory, one read and one write port, registered read,
// per-entry valid bits so entries read as zero after reset. Depends on rbh_pkg.
module rbh_ram #(
    parameter int DEPTH = rbh_pkg::BINS_DEF,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [rbh_pkg::TOTAL_W-1:0]   o_rd_data,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [rbh_pkg::TOTAL_W-1:0]   i_wr_data
);

    logic [rbh_pkg::TOTAL_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            r_vld;
    logic [rbh_pkg::TOTAL_W-1:0] r_rd_data;

    // storage and registered read (old data on same-address write)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? mem[i_rd_addr] : '0;
        end
    end

    // valid bits: cleared by reset, set on first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/rank_bucket_histogram.sv
// rank_bucket_histogram: an item is accepted when start is high and busy is low.
// A rank holds busy through the divide, a read and a write-back; no new item is taken until busy drops.
// An end-of-query item adds a sweep that clears every counter and reports the active bins;
// the bins appear on the ports in order from bin 0, one bin per cycle.
// Synchronous active-low reset: counters read zero, registers take their defaults.
// Results cannot be stalled; the last bin can fall in the first cycle after busy drops.
`include "rank_bucket_histogram_defines.svh"

module rank_bucket_histogram #(
    parameter int BINS = rbh_pkg::BINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          start,
    output logic                          busy,
    input  logic [rbh_pkg::RANK_W-1:0]    i_rank,
    input  logic                          i_end_of_query,
    // result channel
    output logic                          o_bin_valid,
    output logic [rbh_pkg::TOTAL_W-1:0]   o_bin_total,
    output logic [rbh_pkg::BINNO_W-1:0]   o_bin_number,
    output logic                          o_last_bin,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam logic [rbh_pkg::QW-1:0] NB_MAX = rbh_pkg::QW'(BINS);
    localparam logic [AW-1:0] PTR_LAST = AW'(BINS - 1);

    // configuration registers
    logic [rbh_pkg::WIDTH_W-1:0] r_bucket_width;
    logic [rbh_pkg::COUNT_W-1:0] r_item_count;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_width <= rbh_pkg::BUCKET_WIDTH_RST;
            r_item_count   <= rbh_pkg::ITEM_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                rbh_pkg::REG_BUCKET_WIDTH: r_bucket_width <= pwdata[rbh_pkg::WIDTH_W-1:0];
                rbh_pkg::REG_ITEM_COUNT:   r_item_count   <= pwdata[rbh_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rbh_pkg::REG_BUCKET_WIDTH: prdata = 32'(r_bucket_width);
            rbh_pkg::REG_ITEM_COUNT:   prdata = 32'(r_item_count);
            default:                   prdata = '0;
        endcase
    end

    // sequencer registers
    rbh_pkg::t_state            r_state, n_state;
    logic                       r_rank_le1, n_rank_le1;
    logic                       r_eoq, n_eoq;
    logic [AW-1:0]              r_bin, n_bin;
    logic [rbh_pkg::QW-1:0]     r_nbins, n_nbins;
    logic [AW-1:0]              r_ptr, n_ptr;
    logic                       r_rep_vld, n_rep_vld;
    logic                       r_rep_last, n_rep_last;
    logic [rbh_pkg::BINNO_W-1:0] r_rep_num, n_rep_num;

    logic                       accept;
    logic [rbh_pkg::DEN_W-1:0]  eff_w;
    logic [rbh_pkg::NUM_W-1:0]  num_n;
    logic [rbh_pkg::NUM_W-1:0]  num_b;
    logic                       div_n_done;
    logic                       div_b_done;
    logic [rbh_pkg::QW-1:0]     quot_n;
    logic [rbh_pkg::QW-1:0]     quot_b;
    logic [rbh_pkg::QW-1:0]     nb;
    logic [rbh_pkg::QW-1:0]     bin_raw;

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [rbh_pkg::TOTAL_W-1:0] rd_data;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [rbh_pkg::TOTAL_W-1:0] wr_data;

    assign busy   = (r_state != rbh_pkg::S_IDLE);
    assign accept = start && !busy;

    // divider operands: ceil(item_count / width) and (rank - 1) / width
    assign eff_w = (r_bucket_width == '0) ? rbh_pkg::DEN_W'(1) : r_bucket_width;
    assign num_n = rbh_pkg::NUM_W'(r_item_count) + rbh_pkg::NUM_W'(eff_w)
                 - rbh_pkg::NUM_W'(1);
    assign num_b = (i_rank <= rbh_pkg::RANK_W'(1))
                 ? '0 : rbh_pkg::NUM_W'(i_rank) - rbh_pkg::NUM_W'(1);

    rbh_div u_div_nbins (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (num_n),
        .i_den   (eff_w),
        .o_done  (div_n_done),
        .o_quot  (quot_n)
    );

    rbh_div u_div_bin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (num_b),
        .i_den   (eff_w),
        .o_done  (div_b_done),
        .o_quot  (quot_b)
    );

    rbh_ram #(
        .DEPTH (BINS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // active bin count and clamped bin index
    always_comb begin
        nb = (quot_n == '0) ? rbh_pkg::QW'(1) : quot_n;
        if (nb > NB_MAX) begin
            nb = NB_MAX;
        end
        bin_raw = r_rank_le1 ? '0 : quot_b + rbh_pkg::QW'(1);
        if (bin_raw >= nb) begin
            bin_raw = nb - rbh_pkg::QW'(1);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rbh_pkg::S_IDLE;
            r_rep_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rep_vld <= n_rep_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank_le1 <= n_rank_le1;
        r_eoq      <= n_eoq;
        r_bin      <= n_bin;
        r_nbins    <= n_nbins;
        r_ptr      <= n_ptr;
        r_rep_last <= n_rep_last;
        r_rep_num  <= n_rep_num;
    end

    // next state, memory control and report tags
    always_comb begin
        n_state    = r_state;
        n_rank_le1 = r_rank_le1;
        n_eoq      = r_eoq;
        n_bin      = r_bin;
        n_nbins    = r_nbins;
        n_ptr      = r_ptr;
        n_rep_vld  = 1'b0;
        n_rep_last = 1'b0;
        n_rep_num  = r_rep_num;
        rd_en      = 1'b0;
        rd_addr    = r_bin;
        wr_en      = 1'b0;
        wr_addr    = r_bin;
        wr_data    = (rd_data == rbh_pkg::CNT_MAX) ? rd_data
                   : rd_data + rbh_pkg::TOTAL_W'(1);
        unique case (r_state)
            rbh_pkg::S_IDLE: begin
                if (accept) begin
                    n_rank_le1 = (i_rank <= rbh_pkg::RANK_W'(1));
                    n_eoq      = i_end_of_query;
                    n_state    = rbh_pkg::S_DIV;
                end
            end
            rbh_pkg::S_DIV: begin
                if (div_n_done) begin
                    n_nbins = nb;
                    n_bin   = AW'(bin_raw);
                    n_state = rbh_pkg::S_READ;
                end
            end
            rbh_pkg::S_READ: begin
                rd_en   = 1'b1;
                n_state = rbh_pkg::S_UPD;
            end
            rbh_pkg::S_UPD: begin
                wr_en = 1'b1;
                n_ptr = '0;
                n_state = r_eoq ? rbh_pkg::S_DUMP : rbh_pkg::S_IDLE;
            end
            rbh_pkg::S_DUMP: begin
                // read out and zero one entry a cycle
                rd_en      = 1'b1;
                rd_addr    = r_ptr;
                wr_en      = 1'b1;
                wr_addr    = r_ptr;
                wr_data    = '0;
                n_rep_vld  = (rbh_pkg::QW'(r_ptr) < r_nbins);
                n_rep_last = (rbh_pkg::QW'(r_ptr) + rbh_pkg::QW'(1) == r_nbins);
                n_rep_num  = rbh_pkg::BINNO_W'(r_ptr);
                n_ptr      = r_ptr + AW'(1);
                if (r_ptr == PTR_LAST) begin
                    n_state = rbh_pkg::S_IDLE;
                end
            end
            default: n_state = rbh_pkg::S_IDLE;
        endcase
    end

    assign o_bin_valid  = r_rep_vld;
    assign o_bin_total  = rd_data;
    assign o_bin_number = r_rep_num;
    assign o_last_bin   = r_rep_vld && r_rep_last;

    // checks
    `RBH_ASSERT_NOW(a_div_in_step, i_clk, i_rst_n, div_n_done, div_b_done, "divider units out of step")
    `RBH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy, "accepted item did not raise busy")
    `RBH_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_last_bin, !o_bin_valid, "result after last bin")
    `RBH_ASSERT_NOW(a_rep_in_sweep, i_clk, i_rst_n, o_bin_valid && !o_last_bin, busy, "report outside sweep")

endmodule
